// File: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // Decoder mode
   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_STRING = 2'd1,
      MODE_ESCAPE = 2'd2,
      MODE_HEX    = 2'd3
   } mode_type;

   // Result kind
   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // Error cause
   typedef enum logic [2:0] {
      CAUSE_NONE       = 3'd0,
      CAUSE_NO_QUOTE   = 3'd1,
      CAUSE_BAD_ESCAPE = 3'd2,
      CAUSE_BAD_HEX    = 3'd3,
      CAUSE_ENDED      = 3'd4
   } cause_type;

   // Source characters
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;

   // UTF-8 lead and continuation marks
   localparam logic [7:0] UTF8_CONT  = 8'h80;
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;

   // Results caused by one request: up to three data bytes, then an
   // optional done or error result.
   typedef struct packed {
      logic [1:0]      n_bytes;
      logic [2:0][7:0] bytes;
      logic            has_tail;
      kind_type        tail_kind;
      cause_type       tail_cause;
   } bundle_type;

   // Hex digit value; bit 4 flags a valid digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b1, 4'(c - 8'h37)};
      end
      return v;
   endfunction

endpackage

// File: design/json_string_unescape_utf8.sv
// Latency: first result of a request is shown the cycle after it is accepted.
// Throughput: one request per cycle when each gives at most one result and
//   the receiver does not stall; a request that gives several results holds
//   the result register until its last result leaves, and the input is stalled.
// Reset: synchronous, active high; decoder idle awaiting an opening quote,
//   result register empty.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a JSON string literal byte stream, escapes and \uXXXX to UTF-8.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_error_cause,
   output logic       rsp_last
);
   import jsu_pkg::*;

   bundle_type bundle;
   logic       load_ready;
   logic       accept;

   assign req_stall = !load_ready;
   assign accept    = req_valid && load_ready;

   // Decode one request
   jsu_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .end_of_text (req_end_of_text),
      .bundle      (bundle)
   );

   // Serialize its results
   jsu_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .bundle_in       (bundle),
      .load_ready      (load_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_error_cause (rsp_error_cause),
      .rsp_last        (rsp_last)
   );

endmodule

// File: design/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Decoder state and the single-pass decode of one source byte into a bundle.
// ----------------------------------------------------------------------------
module jsu_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               end_of_text,
   output jsu_pkg::bundle_type bundle
);
   import jsu_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [1:0]  digits_ff, digits_in;
   logic [11:0] acc_ff, acc_in;

   logic [4:0]  hv;
   logic [15:0] code;
   logic [7:0]  esc_byte;
   logic        esc_known;
   logic        produced;
   logic        go_idle;

   assign hv   = hex_value(data_byte);
   assign code = {acc_ff, hv[3:0]};

   // Simple escape table
   always_comb begin
      esc_known = 1'b1;
      case (data_byte)
         CHAR_QUOTE:     esc_byte = CHAR_QUOTE;
         CHAR_BACKSLASH: esc_byte = CHAR_BACKSLASH;
         CHAR_SLASH:     esc_byte = CHAR_SLASH;
         CHAR_B:         esc_byte = 8'h08;
         CHAR_F:         esc_byte = 8'h0C;
         CHAR_N:         esc_byte = 8'h0A;
         CHAR_R:         esc_byte = 8'h0D;
         CHAR_T:         esc_byte = 8'h09;
         default: begin
            esc_byte  = 8'h00;
            esc_known = 1'b0;
         end
      endcase
   end

   // Next state and results for this request
   always_comb begin
      mode_in   = mode_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      bundle    = '0;
      bundle.tail_kind  = KIND_BYTE;
      bundle.tail_cause = CAUSE_NONE;
      produced  = 1'b0;
      go_idle   = 1'b0;

      case (mode_ff)
         MODE_IDLE: begin
            if (data_byte != CHAR_QUOTE) begin
               bundle.has_tail   = 1'b1;
               bundle.tail_kind  = KIND_ERROR;
               bundle.tail_cause = CAUSE_NO_QUOTE;
               go_idle = 1'b1;
            end else if (end_of_text) begin
               bundle.has_tail   = 1'b1;
               bundle.tail_kind  = KIND_ERROR;
               bundle.tail_cause = CAUSE_ENDED;
               go_idle = 1'b1;
            end else begin
               mode_in = MODE_STRING;
            end
         end
         MODE_STRING: begin
            if (data_byte == CHAR_QUOTE) begin
               bundle.has_tail  = 1'b1;
               bundle.tail_kind = KIND_DONE;
               go_idle = 1'b1;
            end else if (data_byte == CHAR_BACKSLASH) begin
               if (end_of_text) begin
                  bundle.has_tail   = 1'b1;
                  bundle.tail_kind  = KIND_ERROR;
                  bundle.tail_cause = CAUSE_ENDED;
                  go_idle = 1'b1;
               end else begin
                  mode_in = MODE_ESCAPE;
               end
            end else begin
               bundle.n_bytes  = 2'd1;
               bundle.bytes[0] = data_byte;
               produced = 1'b1;
            end
         end
         MODE_ESCAPE: begin
            if (esc_known) begin
               bundle.n_bytes  = 2'd1;
               bundle.bytes[0] = esc_byte;
               mode_in  = MODE_STRING;
               produced = 1'b1;
            end else if (data_byte == CHAR_U) begin
               if (end_of_text) begin
                  bundle.has_tail   = 1'b1;
                  bundle.tail_kind  = KIND_ERROR;
                  bundle.tail_cause = CAUSE_ENDED;
                  go_idle = 1'b1;
               end else begin
                  mode_in   = MODE_HEX;
                  digits_in = 2'd0;
                  acc_in    = 12'd0;
               end
            end else begin
               bundle.has_tail   = 1'b1;
               bundle.tail_kind  = KIND_ERROR;
               bundle.tail_cause = CAUSE_BAD_ESCAPE;
               go_idle = 1'b1;
            end
         end
         MODE_HEX: begin
            if (digits_ff != 2'd3 && end_of_text) begin
               bundle.has_tail   = 1'b1;
               bundle.tail_kind  = KIND_ERROR;
               bundle.tail_cause = CAUSE_ENDED;
               go_idle = 1'b1;
            end else if (!hv[4]) begin
               bundle.has_tail   = 1'b1;
               bundle.tail_kind  = KIND_ERROR;
               bundle.tail_cause = CAUSE_BAD_HEX;
               go_idle = 1'b1;
            end else if (digits_ff != 2'd3) begin
               acc_in    = {acc_ff[7:0], hv[3:0]};
               digits_in = digits_ff + 2'd1;
            end else begin
               // Fourth digit: encode the code point as UTF-8
               if (code[15:7] == 9'd0) begin
                  bundle.n_bytes  = 2'd1;
                  bundle.bytes[0] = code[7:0];
               end else if (code[15:11] == 5'd0) begin
                  bundle.n_bytes  = 2'd2;
                  bundle.bytes[0] = UTF8_LEAD2 | {3'b000, code[10:6]};
                  bundle.bytes[1] = UTF8_CONT | {2'b00, code[5:0]};
               end else begin
                  bundle.n_bytes  = 2'd3;
                  bundle.bytes[0] = UTF8_LEAD3 | {4'b0000, code[15:12]};
                  bundle.bytes[1] = UTF8_CONT | {2'b00, code[11:6]};
                  bundle.bytes[2] = UTF8_CONT | {2'b00, code[5:0]};
               end
               mode_in   = MODE_STRING;
               digits_in = 2'd0;
               acc_in    = 12'd0;
               produced  = 1'b1;
            end
         end
         default: begin
            go_idle = 1'b1;
         end
      endcase

      // Data followed by end of text is still an error
      if (produced && end_of_text) begin
         bundle.has_tail   = 1'b1;
         bundle.tail_kind  = KIND_ERROR;
         bundle.tail_cause = CAUSE_ENDED;
         go_idle = 1'b1;
      end

      if (go_idle) begin
         mode_in   = MODE_IDLE;
         digits_in = 2'd0;
         acc_in    = 12'd0;
      end
   end

   // State registers, updated per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         digits_ff <= 2'd0;
         acc_ff    <= 12'd0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
      end
   end

   // Digit count and accumulator only live inside a \u sequence
   a_hex_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_HEX) |-> (digits_ff == 2'd0 && acc_ff == 12'd0))
      else $error("hex state not cleared outside \\u");

   // A bundle carries three data bytes and a tail only at end of text
   a_bundle_size: assert property (@(posedge clock) disable iff (reset)
      !(bundle.n_bytes == 2'd3 && bundle.has_tail && !end_of_text))
      else $error("three data bytes with a tail but no end of text");

   // Accepted digits advance the count by one
   a_digit_step: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_HEX && mode_in == MODE_HEX)
         |=> (digits_ff == $past(digits_ff) + 2'd1))
      else $error("hex digit count did not advance");

endmodule

// File: design/jsu_emit.sv
// ----------------------------------------------------------------------------
// jsu_emit
// Result register: holds one bundle and hands out its results one per cycle when not stalled.
// ----------------------------------------------------------------------------
module jsu_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  jsu_pkg::bundle_type bundle_in,
   output logic                load_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_result_kind,
   output logic [7:0]          rsp_out_byte,
   output logic [2:0]          rsp_error_cause,
   output logic                rsp_last
);
   import jsu_pkg::*;

   bundle_type  bundle_ff;
   logic        valid_ff, valid_in;
   logic [1:0]  idx_ff, idx_in;
   logic [2:0]  total;
   logic [2:0]  total_new;
   logic        is_last;
   logic        is_byte;
   logic [7:0]  cur_byte;

   assign total     = {1'b0, bundle_ff.n_bytes} + {2'b00, bundle_ff.has_tail};
   assign total_new = {1'b0, bundle_in.n_bytes} + {2'b00, bundle_in.has_tail};
   assign is_last   = ({1'b0, idx_ff} + 3'd1) == total;
   assign is_byte   = idx_ff < bundle_ff.n_bytes;

   // Free for a new bundle when empty or the last result leaves now
   assign load_ready = !valid_ff || (is_last && !rsp_stall);

   // Current result
   always_comb begin
      case (idx_ff)
         2'd0:    cur_byte = bundle_ff.bytes[0];
         2'd1:    cur_byte = bundle_ff.bytes[1];
         2'd2:    cur_byte = bundle_ff.bytes[2];
         default: cur_byte = 8'h00;
      endcase
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = is_byte ? KIND_BYTE : bundle_ff.tail_kind;
   assign rsp_out_byte    = is_byte ? cur_byte : 8'h00;
   assign rsp_error_cause = is_byte ? CAUSE_NONE : bundle_ff.tail_cause;
   assign rsp_last        = is_last;

   // Index and occupancy
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (valid_ff && !rsp_stall) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (accept && total_new != 3'd0) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // Payload register, no reset
   always_ff @(posedge clock) begin
      if (accept && total_new != 3'd0) begin
         bundle_ff <= bundle_in;
      end
   end

   // The index stays inside the held bundle
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({1'b0, idx_ff} < total))
      else $error("result index past end of bundle");

   // Done and error results always close a request's results
   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !is_byte) |-> is_last)
      else $error("tail result not last");

   // Error results carry a cause, others do not
   a_cause: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ((rsp_result_kind == KIND_ERROR) == (rsp_error_cause != CAUSE_NONE)))
      else $error("error cause mismatch");

endmodule

// File: tb/unescape_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unescape_check_pkg
// Scoreboard for the JSON string unescaper. It tracks the decoder's mode, hex
// digit count and partial code point, and queues the results each accepted
// request should produce. Results from the block are then checked in order.
// ----------------------------------------------------------------------------
package unescape_check_pkg;

   import jsu_pkg::*;

   // One result as seen on the rsp_ channel
   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      cause_type  cause;
      logic       last;
   } decoded_result_type;

   class unescape_checker;

      mode_type           mode;
      logic [1:0]         digits;
      logic [11:0]        partial_code;
      decoded_result_type decoded_results[$];
      decoded_result_type step_results[$];
      int                 failures;

      function new();
         mode         = MODE_IDLE;
         digits       = 2'd0;
         partial_code = 12'd0;
         failures     = 0;
      endfunction

      function int outstanding();
         return decoded_results.size();
      endfunction

      function void emit(kind_type k, logic [7:0] v, cause_type c);
         decoded_result_type r;
         r.kind  = k;
         r.value = v;
         r.cause = c;
         r.last  = 1'b0;
         step_results.push_back(r);
      endfunction

      function void go_idle();
         mode         = MODE_IDLE;
         digits       = 2'd0;
         partial_code = 12'd0;
      endfunction

      // Value of a hex digit, -1 if the byte is not one
      function int nibble_of(logic [7:0] c);
         if (c >= "0" && c <= "9") begin
            return int'(c - "0");
         end else if (c >= "a" && c <= "f") begin
            return int'(c - "a") + 10;
         end else if (c >= "A" && c <= "F") begin
            return int'(c - "A") + 10;
         end
         return -1;
      endfunction

      // UTF-8 of a BMP code point, 1 to 3 bytes
      function void emit_utf8(logic [15:0] code);
         if (code < 16'h0080) begin
            emit(KIND_BYTE, code[7:0], CAUSE_NONE);
         end else if (code < 16'h0800) begin
            emit(KIND_BYTE, UTF8_LEAD2 | {3'b000, code[10:6]}, CAUSE_NONE);
            emit(KIND_BYTE, UTF8_CONT | {2'b00, code[5:0]}, CAUSE_NONE);
         end else begin
            emit(KIND_BYTE, UTF8_LEAD3 | {4'b0000, code[15:12]}, CAUSE_NONE);
            emit(KIND_BYTE, UTF8_CONT | {2'b00, code[11:6]}, CAUSE_NONE);
            emit(KIND_BYTE, UTF8_CONT | {2'b00, code[5:0]}, CAUSE_NONE);
         end
      endfunction

      // Predict the results of one accepted request
      function void unescape_byte(logic [7:0] c, logic ends);
         bit                 gave_data;
         int                 d;
         decoded_result_type r;
         gave_data = 1'b0;
         case (mode)
            MODE_IDLE: begin
               if (c != CHAR_QUOTE) begin
                  emit(KIND_ERROR, 8'h00, CAUSE_NO_QUOTE);
                  go_idle();
               end else if (ends) begin
                  emit(KIND_ERROR, 8'h00, CAUSE_ENDED);
                  go_idle();
               end else begin
                  mode = MODE_STRING;
               end
            end
            MODE_STRING: begin
               if (c == CHAR_QUOTE) begin
                  emit(KIND_DONE, 8'h00, CAUSE_NONE);
                  go_idle();
               end else if (c == CHAR_BACKSLASH) begin
                  if (ends) begin
                     emit(KIND_ERROR, 8'h00, CAUSE_ENDED);
                     go_idle();
                  end else begin
                     mode = MODE_ESCAPE;
                  end
               end else begin
                  emit(KIND_BYTE, c, CAUSE_NONE);
                  gave_data = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               gave_data = 1'b1;
               case (c)
                  CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: emit(KIND_BYTE, c, CAUSE_NONE);
                  CHAR_B: emit(KIND_BYTE, 8'h08, CAUSE_NONE);   // backspace
                  CHAR_F: emit(KIND_BYTE, 8'h0C, CAUSE_NONE);   // form feed
                  CHAR_N: emit(KIND_BYTE, 8'h0A, CAUSE_NONE);   // line feed
                  CHAR_R: emit(KIND_BYTE, 8'h0D, CAUSE_NONE);   // carriage return
                  CHAR_T: emit(KIND_BYTE, 8'h09, CAUSE_NONE);   // tab
                  default: gave_data = 1'b0;
               endcase
               if (gave_data) begin
                  mode = MODE_STRING;
               end else if (c == CHAR_U) begin
                  if (ends) begin
                     emit(KIND_ERROR, 8'h00, CAUSE_ENDED);
                     go_idle();
                  end else begin
                     mode         = MODE_HEX;
                     digits       = 2'd0;
                     partial_code = 12'd0;
                  end
               end else begin
                  emit(KIND_ERROR, 8'h00, CAUSE_BAD_ESCAPE);
                  go_idle();
               end
            end
            default: begin
               d = nibble_of(c);
               // a short \u sequence is reported as ended, valid digit or not
               if (digits < 2'd3 && ends) begin
                  emit(KIND_ERROR, 8'h00, CAUSE_ENDED);
                  go_idle();
               end else if (d < 0) begin
                  emit(KIND_ERROR, 8'h00, CAUSE_BAD_HEX);
                  go_idle();
               end else if (digits < 2'd3) begin
                  partial_code = {partial_code[7:0], 4'(d)};
                  digits       = digits + 2'd1;
               end else begin
                  emit_utf8({partial_code, 4'(d)});
                  mode         = MODE_STRING;
                  digits       = 2'd0;
                  partial_code = 12'd0;
                  gave_data    = 1'b1;
               end
            end
         endcase

         // data followed by the end of the text
         if (gave_data && ends) begin
            emit(KIND_ERROR, 8'h00, CAUSE_ENDED);
            go_idle();
         end

         for (int i = 0; i < step_results.size(); i++) begin
            r      = step_results[i];
            r.last = (i == step_results.size() - 1);
            decoded_results.push_back(r);
         end
         step_results.delete();
      endfunction

      // Compare one result from the block with the oldest prediction
      function void check_result(logic [1:0] kind, logic [7:0] value, logic [2:0] cause,
                                 logic last);
         decoded_result_type e;
         if (decoded_results.size() == 0) begin
            $error("unexpected result: kind %0d byte %0h cause %0d", kind, value, cause);
            failures++;
            return;
         end
         e = decoded_results.pop_front();
         if (kind !== e.kind) begin
            $error("result_kind: expected %0d, got %0d", e.kind, kind);
            failures++;
         end
         if (value !== e.value) begin
            $error("out_byte: expected %0h, got %0h", e.value, value);
            failures++;
         end
         if (cause !== e.cause) begin
            $error("error_cause: expected %0d, got %0d", e.cause, cause);
            failures++;
         end
         if (last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last);
            failures++;
         end
      endfunction

   endclass

endpackage

// File: tb/tb_json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8
// Drives byte streams into the unescaper: directed strings for the \n escape,
// every \u width and every error path, then random well-formed strings mixed
// with noise and broken sequences. Both channels idle at random; results are
// checked in order against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8;

   import jsu_pkg::*;
   import unescape_check_pkg::*;

   localparam int LONG_HOLD  = 60;
   localparam int RUN_LIMIT  = 500000;   // ns

   logic       clock;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte   = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_error_cause;
   logic       rsp_last;

   bit              no_idle       = 1'b0;
   int              hold_asks     = 0;
   int              hold_done     = 0;
   int              hold_left     = 0;
   int              requests_sent = 0;
   unescape_checker board;

   json_string_unescape_utf8 dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_error_cause (rsp_error_cause),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #RUN_LIMIT;
      $display("tb: failure");
      $finish;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
      if (n < 4'd10) begin
         return "0" + 8'(n);
      end
      return (upper ? "A" : "a") + 8'(n - 4'd10);
   endfunction

   function automatic logic [7:0] escape_char(int i);
      case (i)
         0: return CHAR_QUOTE;
         1: return CHAR_BACKSLASH;
         2: return CHAR_SLASH;
         3: return CHAR_B;
         4: return CHAR_F;
         5: return CHAR_N;
         6: return CHAR_R;
         default: return CHAR_T;
      endcase
   endfunction

   // Result side: check accepted results, stall at random or on a long hold
   always @(posedge clock) begin : result_sink
      int g;
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_result_kind, rsp_out_byte, rsp_error_cause, rsp_last);
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_done != hold_asks) begin
         hold_done++;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         g = pick_gap();
         rsp_stall <= (g > 0);
         hold_left = (g > 0) ? g - 1 : 0;
      end
   end

   // Offer one request after a random gap and wait until it is taken
   task automatic send_request(input logic [7:0] d, input logic ends);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= d;
      req_end_of_text <= ends;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.unescape_byte(d, ends);
      requests_sent++;
   endtask

   // Send a string of source bytes; end of text flagged on the last one
   task automatic send_text(input string s, input bit ends_last);
      for (int i = 0; i < s.len(); i++) begin
         send_request(s[i], ends_last && (i == s.len() - 1));
      end
   endtask

   // Stop offering and wait for every predicted result
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   // One random stimulus unit: a string literal, possibly truncated or broken,
   // or a stray byte
   task automatic send_random_text();
      logic [7:0]  text[$];
      logic [7:0]  b;
      logic [15:0] code;
      int          n;
      int          pick;
      int          r;
      bit          ends_last;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         send_request(8'($urandom), 1'($urandom));
         return;
      end
      text.push_back(CHAR_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            do b = 8'($urandom); while (b == CHAR_QUOTE || b == CHAR_BACKSLASH);
            text.push_back(b);
         end else if (pick < 7) begin
            text.push_back(CHAR_BACKSLASH);
            text.push_back(escape_char($urandom_range(0, 7)));
         end else if (pick < 9) begin
            case ($urandom_range(0, 2))
               0: code = 16'($urandom_range(16'h0000, 16'h007F));
               1: code = 16'($urandom_range(16'h0080, 16'h07FF));
               default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            text.push_back(CHAR_BACKSLASH);
            text.push_back(CHAR_U);
            text.push_back(hex_char(code[15:12], 1'($urandom)));
            text.push_back(hex_char(code[11:8], 1'($urandom)));
            text.push_back(hex_char(code[7:4], 1'($urandom)));
            text.push_back(hex_char(code[3:0], 1'($urandom)));
         end else begin
            // broken: arbitrary byte after a backslash or inside \u
            text.push_back(CHAR_BACKSLASH);
            if ($urandom_range(0, 1)) begin
               text.push_back(CHAR_U);
               text.push_back(hex_char(4'($urandom), 1'b0));
            end
            text.push_back(8'($urandom));
         end
      end
      text.push_back(CHAR_QUOTE);
      // end of text: on a random byte, on the closing quote, or not at all
      r         = $urandom_range(0, 99);
      ends_last = (r < 20);
      if (r < 10) begin
         n = $urandom_range(1, text.size());
         while (text.size() > n) void'(text.pop_back());
      end
      for (int i = 0; i < text.size(); i++) begin
         send_request(text[i], ends_last && (i == text.size() - 1));
      end
   endtask

   task automatic random_items(input int count);
      int stop_at;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) send_random_text();
   endtask

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // no opening quote, and an opening quote that ends the text
      send_request(8'hFF, 1'b1);
      send_text("\"", 1'b1);
      // raw extremes, code zero, 2-byte, 3-byte code ending the text
      send_request(CHAR_QUOTE, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_text("\\u0000\\u07Ff\\uFfFF", 1'b1);
      // unknown escape; surrogate half then a bad hex digit
      send_text("\"\\q", 1'b0);
      send_text("\"\\uDc00\\uG", 1'b0);
      // text ending inside \u, after a backslash, after u
      send_text("\"\\u1", 1'b1);
      send_text("\"\\", 1'b1);
      send_text("\"\\u", 1'b1);
      // plain and escaped byte at end of text, closing quote at end of text
      send_text("\"a", 1'b1);
      send_text("\"\\n", 1'b1);
      send_text("\"\"", 1'b1);

      random_items(15);

      // long receiver hold while requests keep coming back to back
      hold_asks++;
      no_idle = 1'b1;
      random_items(25);
      no_idle = 1'b0;
      drain_results();

      random_items(55);

      drain_results();
      repeat (8) @(posedge clock);
      if (board.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
